FILE: hdl/rkfce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_pkg
// Shared types and constants of the Fehlberg 4(5) combine and error block.
// ----------------------------------------------------------------------------
package rkfce_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int GUARD_BITS    = 16;
	localparam int COEF_BITS     = 30;
	localparam int STEP_WIDTH    = 31;
	localparam int NORM_WIDTH    = 32;
	localparam int RATIO_BITS    = 30;
	localparam int TERMS         = 5;
	localparam int ACC_WIDTH     = 64;
	localparam int PROD_SHIFT    = COEF_BITS + FRACTION_BITS - GUARD_BITS;
	localparam int TERM_IDX_W    = $clog2(TERMS);

	localparam logic [STEP_WIDTH-1:0] STEP_RESET = 31'd6554;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [COEF_BITS-1:0]          coef_t;

	typedef struct packed {
		value_t                           start_value;
		logic [TERMS-1:0][VALUE_WIDTH-1:0] stage;
		logic                             is_last;
	} item_t;

	// fifth-order weights b5 (k1, k3, k4, k5, k6) as Q0.30 magnitudes
	localparam coef_t FIFTH_W [TERMS] = '{
		30'd127258290, 30'd557257355, 30'd543454550, 30'd193273528, 30'd39045157
	};
	localparam logic [TERMS-1:0] FIFTH_NEG = 5'b01000;

	// fifth minus fourth weights
	localparam coef_t ERR_W [TERMS] = '{
		30'd2982616, 30'd32149463, 30'd31353147, 30'd21474836, 30'd39045157
	};
	localparam logic [TERMS-1:0] ERR_NEG = 5'b00110;

endpackage

FILE: hdl/rkfce_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_item_if
// Input request channel: one state element and its stage derivatives.
// ----------------------------------------------------------------------------
interface rkfce_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_value;
	logic [31:0] stage_one;
	logic [31:0] stage_three;
	logic [31:0] stage_four;
	logic [31:0] stage_five;
	logic [31:0] stage_six;
	logic        is_last;

	modport source (output valid, start_value, stage_one, stage_three, stage_four,
		stage_five, stage_six, is_last, input ready);
	modport sink (input valid, start_value, stage_one, stage_three, stage_four,
		stage_five, stage_six, is_last, output ready);
endinterface

FILE: hdl/rkfce_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_result_if
// Result channel: updated element and running error norm.
// ----------------------------------------------------------------------------
interface rkfce_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_value;
	logic [31:0] peak_ratio;
	logic        norm_done;

	modport source (output valid, new_value, peak_ratio, norm_done, input ready);
	modport sink (input valid, new_value, peak_ratio, norm_done, output ready);
endinterface

FILE: hdl/rkfce_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_cfg_if
// Configuration write channel for the step size register.
// ----------------------------------------------------------------------------
interface rkfce_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hdl/rkfce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_front
// Input stage: takes requests, packs them into items and pushes to the queue.
// ----------------------------------------------------------------------------
module rkfce_front
	import rkfce_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rkfce_item_if.sink   items,
	output logic         push,
	output item_t        push_item,
	input  logic         full
);

	logic  valid_s1;
	item_t item_s1;

	assign push      = valid_s1 && !full;
	assign push_item = item_s1;
	assign items.ready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.start_value <= items.start_value;
			item_s1.stage[0]    <= items.stage_one;
			item_s1.stage[1]    <= items.stage_three;
			item_s1.stage[2]    <= items.stage_four;
			item_s1.stage[3]    <= items.stage_five;
			item_s1.stage[4]    <= items.stage_six;
			item_s1.is_last     <= items.is_last;
		end
	end

endmodule

FILE: hdl/rkfce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_queue
// Small item queue between the input stage and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module rkfce_queue
	import rkfce_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	localparam int ADDR_W = $clog2(DEPTH);

	item_t             mem [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W:0]   count_q;

	assign full      = (count_q == (ADDR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == ADDR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == ADDR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hdl/rkfce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfce_back
// Arithmetic sequencer: weighted sums on one shared multiplier, step scaling,
// bit-serial ratio division and the running maximum.
// ----------------------------------------------------------------------------
module rkfce_back
	import rkfce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	input  logic [STEP_WIDTH-1:0] step_size,
	rkfce_result_if.source        results
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_SLO, ST_SHI, ST_SCOMB, ST_DIFF, ST_SCALE, ST_DIV, ST_FIN
	} state_t;

	localparam logic [ACC_WIDTH-1:0] UNIT_SCALE = ACC_WIDTH'(1) << (FRACTION_BITS + GUARD_BITS);
	localparam logic [95:0]          ROUND_HALF = 96'(1) << (PROD_SHIFT - 1);
	localparam logic [ACC_WIDTH:0]   OUT_HALF   = (ACC_WIDTH+1)'(1) << (GUARD_BITS - 1);
	localparam logic [ACC_WIDTH:0]   OUT_MAX    =
		(ACC_WIDTH+1)'({(VALUE_WIDTH-1){1'b1}});

	state_t                  state_q;
	item_t                   item_q;
	logic                    sel_err_q;
	logic [TERM_IDX_W-1:0]   idx_q;
	logic signed [64:0]      prod_q;
	logic [ACC_WIDTH-1:0]    acc_q;
	logic [ACC_WIDTH-1:0]    smag_q;
	logic                    sneg_q;
	logic [ACC_WIDTH-1:0]    lo_q;
	logic [ACC_WIDTH-1:0]    fifth_q;
	logic [ACC_WIDTH-1:0]    fourth_q;
	logic [ACC_WIDTH-1:0]    diff_q;
	logic [ACC_WIDTH-1:0]    den_q;
	logic [ACC_WIDTH+1:0]    rem_q;
	logic [NORM_WIDTH-1:0]   quot_q;
	logic [4:0]              cnt_q;
	logic [VALUE_WIDTH-1:0]  nv_q;
	logic [NORM_WIDTH-1:0]   run_q;
	logic                    out_valid_q;
	logic [VALUE_WIDTH-1:0]  out_value_q;
	logic [NORM_WIDTH-1:0]   out_norm_q;
	logic                    out_done_q;

	logic signed [32:0]     mul_a;
	logic signed [31:0]     mul_b;
	logic signed [64:0]     mul_p;
	logic                   out_free;
	coef_t                  coef;
	logic                   coef_neg;
	logic [ACC_WIDTH-1:0]   acc_next;
	logic [95:0]            wide;
	logic [ACC_WIDTH-1:0]   scaled;
	logic [ACC_WIDTH-1:0]   ext_y;
	logic [ACC_WIDTH-1:0]   a5;
	logic [ACC_WIDTH-1:0]   a4;
	logic [ACC_WIDTH-1:0]   den;
	logic [ACC_WIDTH:0]     om;
	logic [ACC_WIDTH+1:0]   dv;
	logic [ACC_WIDTH+1:0]   rs;
	logic [NORM_WIDTH-1:0]  new_max;

	function automatic logic [ACC_WIDTH-1:0] mag(input logic [ACC_WIDTH-1:0] v);
		return v[ACC_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	assign out_free = !out_valid_q || results.ready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid && out_free;

	assign results.valid      = out_valid_q;
	assign results.new_value  = out_value_q;
	assign results.peak_ratio = out_norm_q;
	assign results.norm_done  = out_done_q;

	// shared multiplier
	always_comb begin
		coef     = sel_err_q ? ERR_W[idx_q] : FIFTH_W[idx_q];
		coef_neg = sel_err_q ? ERR_NEG[idx_q] : FIFTH_NEG[idx_q];
		case (state_q)
			ST_SLO: begin
				mul_a = $signed({1'b0, smag_q[31:0]});
				mul_b = $signed({1'b0, step_size});
			end
			ST_SHI: begin
				mul_a = $signed({1'b0, smag_q[63:32]});
				mul_b = $signed({1'b0, step_size});
			end
			default: begin
				mul_a = $signed({item_q.stage[idx_q][VALUE_WIDTH-1], item_q.stage[idx_q]});
				mul_b = $signed({2'b00, coef});
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		acc_next = coef_neg ? acc_q - prod_q[63:0] : acc_q + prod_q[63:0];
		wide     = {prod_q[63:0], 32'd0} + {32'd0, lo_q} + ROUND_HALF;
		scaled   = sneg_q ? (~wide[93:30] + 1'b1) : wide[93:30];
		ext_y    = ACC_WIDTH'($signed(item_q.start_value)) << GUARD_BITS;
		a5       = mag(fifth_q);
		a4       = mag(fourth_q);
		den      = UNIT_SCALE;
		if (a5 > den) den = a5;
		if (a4 > den) den = a4;
		om       = ({1'b0, a5} + OUT_HALF) >> GUARD_BITS;
		dv       = (cnt_q == 5'd0) ? {1'b0, den_q, 1'b0} : {2'b00, den_q};
		rs       = (cnt_q >= 5'd2) ? {rem_q[ACC_WIDTH:0], 1'b0} : rem_q;
		new_max  = (quot_q > run_q) ? quot_q : run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			run_q       <= '0;
			sel_err_q   <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && results.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						item_q    <= q_item;
						acc_q     <= '0;
						idx_q     <= '0;
						sel_err_q <= 1'b0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (idx_q == TERM_IDX_W'(TERMS-1)) begin
						smag_q  <= mag(acc_next);
						sneg_q  <= acc_next[ACC_WIDTH-1];
						state_q <= ST_SLO;
					end else begin
						acc_q   <= acc_next;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_SLO: begin
					prod_q  <= mul_p;
					state_q <= ST_SHI;
				end
				ST_SHI: begin
					lo_q    <= prod_q[63:0];
					prod_q  <= mul_p;
					state_q <= ST_SCOMB;
				end
				ST_SCOMB: begin
					if (!sel_err_q) begin
						fifth_q   <= ext_y + scaled;
						sel_err_q <= 1'b1;
						acc_q     <= '0;
						idx_q     <= '0;
						state_q   <= ST_MUL;
					end else begin
						diff_q  <= scaled;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					fourth_q <= fifth_q - diff_q;
					state_q  <= ST_SCALE;
				end
				ST_SCALE: begin
					den_q  <= den;
					rem_q  <= {2'b00, mag(diff_q)};
					quot_q <= '0;
					cnt_q  <= '0;
					// round to output format and saturate
					if (fifth_q[ACC_WIDTH-1]) begin
						nv_q <= (om > OUT_MAX) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
							: ~om[VALUE_WIDTH-1:0] + 1'b1;
					end else begin
						nv_q <= (om > OUT_MAX) ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
							: om[VALUE_WIDTH-1:0];
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rs >= dv) begin
						rem_q  <= rs - dv;
						quot_q <= {quot_q[NORM_WIDTH-2:0], 1'b1};
					end else begin
						rem_q  <= rs;
						quot_q <= {quot_q[NORM_WIDTH-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(RATIO_BITS + 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					out_valid_q <= 1'b1;
					out_value_q <= nv_q;
					out_norm_q  <= new_max;
					out_done_q  <= item_q.is_last;
					run_q       <= item_q.is_last ? '0 : new_max;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fin_presents: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> out_valid_q)
		else $error("finished item not presented");

	a_norm_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && item_q.is_last) |=> run_q == '0)
		else $error("running max not cleared after last element");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !out_valid_q)
		else $error("result register overwritten");

	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> den_q >= UNIT_SCALE)
		else $error("divisor below unit scale");

endmodule

FILE: hdl/rkf45_real_combine_error_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkf45_real_combine_error_core
// Fehlberg 4(5) element combiner with scaled infinity-norm error tracking.
// ----------------------------------------------------------------------------
// path from request to result: input register, queue, sequencer
// the sequencer takes a new item only when idle and done with the last one:
//   weighted sums and step scaling on one shared multiplier, a bit-serial
//   ratio divider, then handoff and setup
// reset: asynchronous, clears queue, sequencer, running max; step size 6554
module rkf45_real_combine_error_core
	import rkfce_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	rkfce_item_if.sink      items,
	rkfce_result_if.source  results,
	rkfce_cfg_if.sink       cfg
);

	logic [STEP_WIDTH-1:0] step_q;
	logic                  push;
	item_t                 push_item;
	logic                  full;
	logic                  pop;
	logic                  not_empty;
	item_t                 pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg.valid) begin
			step_q <= cfg.data;
		end
	end

	rkfce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	rkfce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	rkfce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_item    (pop_item),
		.q_pop     (pop),
		.step_size (step_q),
		.results   (results)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams state elements with random stage derivatives through the Fehlberg
// combiner and checks each updated element and running error norm against
// a local fixed-point predictor, across several step sizes.
// ----------------------------------------------------------------------------
module testbench;
	import rkfce_pkg::*;

	typedef struct {
		logic [31:0] start_value;
		logic [31:0] k [TERMS];
		logic        is_last;
	} element_t;

	typedef struct {
		logic [31:0] new_value;
		logic [31:0] peak_ratio;
		logic        norm_done;
	} combine_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rkfce_item_if   items ();
	rkfce_result_if results ();
	rkfce_cfg_if    cfg ();

	rkf45_real_combine_error_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items.sink),
		.results(results.source),
		.cfg    (cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	element_t    pending_elements [$];
	combine_t    expected_combines [$];
	logic [30:0] model_step;
	logic [31:0] model_max;
	int          mismatches = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          cfg_pending = 1'b0;
	bit          item_taken = 1'b0;
	logic [30:0] cfg_value;

	// magnitude-sign product of a weighted sum and the step, rounded half away
	function automatic logic signed [127:0] scaled_sum(input logic signed [127:0] s,
			input logic [30:0] h);
		logic [127:0] m;
		logic [127:0] r;
		m = (s < 0) ? -s : s;
		r = (m * h + (128'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
		return (s < 0) ? -$signed(r) : $signed(r);
	endfunction

	function automatic combine_t predict_combine(input element_t e);
		logic signed [127:0] s5, se, fifth, fourth, diff, rounded;
		logic [127:0]        a5, a4, ad, scale, ratio, mag;
		logic signed [127:0] kv;
		combine_t            c;
		s5 = 0;
		se = 0;
		for (int i = 0; i < TERMS; i++) begin
			kv = $signed(e.k[i]);
			if (FIFTH_NEG[i]) s5 = s5 - kv * $signed({1'b0, FIFTH_W[i]});
			else s5 = s5 + kv * $signed({1'b0, FIFTH_W[i]});
			if (ERR_NEG[i]) se = se - kv * $signed({1'b0, ERR_W[i]});
			else se = se + kv * $signed({1'b0, ERR_W[i]});
		end
		fifth = ($signed(e.start_value) <<< GUARD_BITS) + scaled_sum(s5, model_step);
		diff = scaled_sum(se, model_step);
		fourth = fifth - diff;
		a5 = (fifth < 0) ? -fifth : fifth;
		a4 = (fourth < 0) ? -fourth : fourth;
		ad = (diff < 0) ? -diff : diff;
		scale = 128'd1 << (FRACTION_BITS + GUARD_BITS);
		if (a5 > scale) scale = a5;
		if (a4 > scale) scale = a4;
		ratio = (ad << RATIO_BITS) / scale;
		if (ratio[31:0] > model_max) model_max = ratio[31:0];
		mag = (a5 + (128'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
		if (fifth < 0) rounded = (mag > 128'h7FFFFFFF) ? -128'sh80000000 : -$signed(mag);
		else rounded = (mag > 128'h7FFFFFFF) ? 128'sh7FFFFFFF : $signed(mag);
		c.new_value = rounded[31:0];
		c.peak_ratio = model_max;
		c.norm_done = e.is_last;
		if (e.is_last) model_max = '0;
		return c;
	endfunction

	function automatic logic [31:0] random_value(input int mode);
		case (mode)
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 200000) - 100000;
			3: return {{16{1'b0}}, 16'($urandom)} ^ ({32{$urandom_range(0, 1) == 1}});
			default: return $urandom;
		endcase
	endfunction

	task automatic add_element(input logic [31:0] y, input logic [31:0] k0,
			input logic [31:0] k1, input logic [31:0] k2, input logic [31:0] k3,
			input logic [31:0] k4, input logic last);
		element_t e;
		e.start_value = y;
		e.k[0] = k0; e.k[1] = k1; e.k[2] = k2; e.k[3] = k3; e.k[4] = k4;
		e.is_last = last;
		pending_elements.push_back(e);
	endtask

	task automatic add_random(input int count);
		element_t e;
		int       wide;
		for (int n = 0; n < count; n++) begin
			wide = $urandom_range(0, 9);
			e.start_value = random_value(wide < 2 ? $urandom_range(0, 4) : $urandom_range(2, 4));
			for (int i = 0; i < TERMS; i++)
				e.k[i] = random_value(wide < 2 ? $urandom_range(0, 4) : $urandom_range(2, 4));
			e.is_last = ($urandom_range(0, 5) == 0);
			pending_elements.push_back(e);
		end
	endtask

	task automatic write_step(input logic [30:0] h);
		// let any in-flight request drain before touching the register
		wait (pending_elements.size() == 0 && expected_combines.size() == 0);
		repeat (70) @(posedge clk);
		@(negedge clk);
		cfg_value = h;
		cfg_pending = 1'b1;
		wait (!cfg_pending);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
			items.start_value <= '0;
			items.stage_one <= '0;
			items.stage_three <= '0;
			items.stage_four <= '0;
			items.stage_five <= '0;
			items.stage_six <= '0;
			items.is_last <= 1'b0;
			cfg.valid <= 1'b0;
			cfg.data <= '0;
			results.ready <= 1'b0;
		end else begin
			results.ready <= calm || ($urandom_range(0, 99) >= 38);
			cfg.valid <= cfg_pending;
			cfg.data <= cfg_value;
			// a request stays on the bus until the edge that takes it
			if (!items.valid || item_taken) begin
				if (pending_elements.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
					items.valid <= 1'b1;
					items.start_value <= pending_elements[0].start_value;
					items.stage_one <= pending_elements[0].k[0];
					items.stage_three <= pending_elements[0].k[1];
					items.stage_four <= pending_elements[0].k[2];
					items.stage_five <= pending_elements[0].k[3];
					items.stage_six <= pending_elements[0].k[4];
					items.is_last <= pending_elements[0].is_last;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		element_t e;
		combine_t c;
		item_taken = items.valid && items.ready;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cfg.valid && cfg.ready) begin
				model_step = cfg.data;
				cfg_pending = 1'b0;
			end
			if (items.valid && items.ready) begin
				e = pending_elements.pop_front();
				expected_combines.push_back(predict_combine(e));
			end
			if (results.valid && results.ready) begin
				if (expected_combines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", results.new_value);
				end else begin
					c = expected_combines.pop_front();
					if (c.new_value !== results.new_value || c.peak_ratio !== results.peak_ratio
							|| c.norm_done !== results.norm_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h %h %b, got %h %h %b",
								c.new_value, c.peak_ratio, c.norm_done,
								results.new_value, results.peak_ratio, results.norm_done);
					end
				end
			end
			if (cycles > 800000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] mx, mn;
		mx = 32'h7FFFFFFF;
		mn = 32'h80000000;
		model_step = STEP_RESET;
		model_max = '0;
		cfg_value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, partial vectors, saturation both ways
		add_element(0, 0, 0, 0, 0, 0, 1'b1);
		add_element(mx, mx, mx, mx, mn, mx, 1'b0);
		add_element(mn, mn, mn, mn, mx, mn, 1'b1);
		add_element(32'h00010000, 32'h00010000, 0, 0, 0, 0, 1'b0);
		add_element(32'hFFFF0000, 0, 32'h00010000, 0, 0, 0, 1'b0);
		add_element(32'h00008000, 0, 0, 32'hFFFF0000, 0, 0, 1'b0);
		add_element(32'hFFFF8000, 0, 0, 0, 32'h00010000, 0, 1'b0);
		add_element(1, 0, 0, 0, 0, 32'h00010000, 1'b1);
		add_element(mx, mx, mx, mx, mx, mx, 1'b1);
		add_element(mn, mn, mn, mn, mn, mn, 1'b1);
		add_element(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		add_random(300);

		// step size extremes: largest forces saturation, smallest nearly passes y
		write_step(31'h7FFFFFFF);
		add_element(mx, mx, mx, mx, mn, mx, 1'b0);
		add_element(mn, mn, mn, mn, mx, mn, 1'b1);
		add_random(300);
		write_step(31'd1);
		add_random(300);
		write_step(31'd0);
		add_element(32'h12345678, mx, mn, mx, mn, mx, 1'b1);
		add_random(150);
		write_step(31'd65536);
		calm = 1'b1;
		add_random(250);
		wait (pending_elements.size() == 0);
		calm = 1'b0;
		add_random(300);
		write_step(31'($urandom));
		add_random(340);

		wait (pending_elements.size() == 0 && expected_combines.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
